// ===== rtl/mml_one_bit_music_player_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MML_ONE_BIT_MUSIC_PLAYER_DEFINES_SVH
`define MML_ONE_BIT_MUSIC_PLAYER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MML_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MML_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/mml_pkg.sv =====
// Package with the types, constant tables and command codes of the music player.
package mml_pkg;

    localparam int SONG_AW = 12;
    localparam int PULSES = 3;
    localparam int DRUM_BYTES = 127;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_PLAY = 2'd1;
    localparam logic [1:0] REQ_STOP = 2'd2;
    localparam logic [1:0] REQ_TICK = 2'd3;

    localparam logic [3:0] HI_REST = 4'd0;
    localparam logic [3:0] HI_OCTAVE = 4'd13;
    localparam logic [3:0] HI_VOLUME = 4'd14;
    localparam logic [3:0] HI_ESCAPE = 4'd15;

    localparam logic [3:0] ESC_LOOP_START = 4'd0;
    localparam logic [3:0] ESC_LOOP_END = 4'd1;
    localparam logic [3:0] ESC_CALL = 4'd2;
    localparam logic [3:0] ESC_TEMPO = 4'd3;
    localparam logic [3:0] ESC_SKIP2A = 4'd4;
    localparam logic [3:0] ESC_SKIP2B = 4'd5;
    localparam logic [3:0] ESC_SKIP1 = 4'd6;
    localparam logic [3:0] ESC_RETURN = 4'd15;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       play;
        logic       stop;
        logic       tick;      // sampler and pulse step, tempo count
        logic       hdr_lo;    // capture high byte of a pointer
        logic       rd;        // issue a song memory read at the current address
        logic [1:0] addr_sel;  // 0 voice pointer, 1 pointer+1, 2 header, 3 header+1
        logic       set_ptr;   // read pointer of voice from assembled pointer
        logic       exec;      // interpret the command byte just read
        logic       exec_arg;  // interpret an escape with its argument
        logic       dec_len;   // count down note length
        logic [1:0] voice;
    } mml_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic active;
        logic reload;      // tempo count is zero at this tick
        logic len_zero;
        logic done;        // a note or rest ended the chain
        logic need_arg;    // escape needs its argument byte
        logic need_ptr;    // escape jumps through a pointer
    } mml_stat_t;

    function automatic logic [10:0] note_period(input logic [3:0] idx);
        logic [10:0] r;
        unique case (idx)
            4'd0: r = 11'd1024;
            4'd1: r = 11'd967;
            4'd2: r = 11'd912;
            4'd3: r = 11'd861;
            4'd4: r = 11'd813;
            4'd5: r = 11'd767;
            4'd6: r = 11'd724;
            4'd7: r = 11'd683;
            4'd8: r = 11'd645;
            4'd9: r = 11'd609;
            4'd10: r = 11'd575;
            4'd11: r = 11'd542;
            default: r = 11'd255;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] drum_start(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0: r = 8'd0;
            3'd1: r = 8'd19;
            3'd2: r = 8'd34;
            3'd3: r = 8'd74;
            3'd4: r = 8'd118;
            default: r = 8'd126;
        endcase
        return r;
    endfunction

    localparam logic [7:0] DRUM_ROM [0:DRUM_BYTES-1] = '{
        8'hAA,8'hB6,8'h87,8'hF8,8'h84,8'h37,8'hE8,8'hC1,8'h07,8'h3D,8'hF8,8'hE0,8'h91,8'h87,
        8'h07,8'h0F,8'h0F,8'h1B,8'h1E,
        8'hAA,8'h2A,8'h33,8'h33,8'h33,8'h33,8'h33,8'hCD,8'hCC,8'hCC,8'hCC,8'hAC,8'h99,8'h31,
        8'h33,
        8'h95,8'hB2,8'h00,8'hE3,8'hF0,8'h00,8'hFF,8'h00,8'hFE,8'h00,8'h00,8'h00,8'hFF,8'hFF,
        8'hFF,8'h25,8'h00,8'h00,8'h00,8'h00,8'hFF,8'hF7,8'hFF,8'hFF,8'hFF,8'hBF,8'h12,8'h00,
        8'h80,8'h00,8'h00,8'h00,8'h00,8'hEE,8'hFF,8'hFF,8'hFF,8'hF7,8'hFF,8'hFE,
        8'h9A,8'h9A,8'hAA,8'h96,8'h74,8'h95,8'h8A,8'hDE,8'h74,8'hA0,8'hF7,8'h25,8'h74,8'h68,
        8'hFF,8'h5B,8'h41,8'h80,8'hD4,8'hFD,8'hDE,8'h12,8'h04,8'h24,8'hED,8'hFB,8'h5B,8'h25,
        8'h04,8'h91,8'h6A,8'hDF,8'h77,8'h15,8'h02,8'h22,8'hD5,8'h7A,8'hEF,8'hB6,8'h24,8'h84,
        8'hA4,8'hDA,
        8'h9A,8'h74,8'hD4,8'h33,8'h33,8'hE8,8'hE8,8'h55,8'h55 };

endpackage

// ===== rtl/mml_datapath.sv =====
// Datapath of the music player: song memory, voice state, pulse and sampler units.
module mml_datapath
    import mml_pkg::*;
#(
    parameter int SONG_BYTES = 4096,
    parameter int LOOP_DEPTH = 4,
    parameter int SAMPLE_DIVIDE = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  mml_cmd_t         cmd,
    input  logic [SONG_AW-1:0] load_address,
    input  logic [7:0]       load_value,
    output mml_stat_t        stat,
    output logic [3:0]       levels
);
    localparam int AW = $clog2(SONG_BYTES);
    localparam int LW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam int CW = $clog2(LOOP_DEPTH + 1);

    logic [7:0] mem [0:SONG_BYTES-1];
    logic [7:0] rdata_reg;
    logic [AW-1:0] addr;

    logic [AW-1:0] rp_reg [0:3];
    logic [AW-1:0] ret_reg [0:3];
    logic [AW-1:0] lstart_reg [0:3][0:LOOP_DEPTH-1];
    logic [7:0] lrem_reg [0:3][0:LOOP_DEPTH-1];
    logic [CW-1:0] llev_reg [0:3];
    logic [6:0] len_reg [0:3];
    logic [7:0] oct_reg [0:3];
    logic [3:0] vol_reg [0:3];
    logic [10:0] per_reg [0:3];
    logic [10:0] duty_reg [0:3];
    logic [15:0] phase_reg [0:PULSES-1];
    logic [3:0] lvl_reg;
    logic [15:0] treload_reg, tcount_reg;
    logic [7:0] sbyte_reg, send_reg, srate_reg;
    logic [3:0] sbit_reg;
    logic active_reg;
    logic [7:0] cmdb_reg;   // command byte held while its argument is read
    logic [7:0] hi_reg;     // high byte of a pointer being assembled
    logic [AW-1:0] hdr_reg; // header address for pointer reads

    logic [1:0] v;
    logic [3:0] ch, cl;
    logic [AW-1:0] p;
    logic [LW-1:0] top;
    logic [AW-1:0] ptr_asm;

    assign v = cmd.voice;
    assign p = rp_reg[v];
    assign ch = rdata_reg[7:4];
    assign cl = rdata_reg[3:0];
    assign ptr_asm = AW'({hi_reg, rdata_reg});

    always_comb begin
        unique case (cmd.addr_sel)
            2'd0: addr = p;
            2'd1: addr = p + AW'(1);
            2'd2: addr = hdr_reg;
            default: addr = hdr_reg + AW'(1);
        endcase
    end

    always_comb begin
        if (llev_reg[v] == '0) top = '0;
        else if (llev_reg[v] > CW'(LOOP_DEPTH)) top = LW'(LOOP_DEPTH - 1);
        else top = LW'(llev_reg[v] - CW'(1));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) mem[AW'(load_address)] <= load_value;
        if (cmd.rd) rdata_reg <= mem[addr];
    end

    assign stat.active = active_reg;
    assign stat.reload = (tcount_reg == 16'd0);
    assign stat.len_zero = (len_reg[v] == 7'd0);
    assign stat.done = (ch != HI_ESCAPE) && (ch != HI_OCTAVE) && (ch != HI_VOLUME);
    assign stat.need_arg = (ch == HI_ESCAPE) && ((cl == ESC_LOOP_START)
                           || (cl == ESC_CALL) || (cl == ESC_TEMPO));
    assign stat.need_ptr = (ch == HI_ESCAPE) && (((cl == ESC_RETURN) && (ret_reg[v] == '0))
                           || (cl == ESC_CALL));
    assign levels = lvl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.stop) begin
            active_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                rp_reg[i] <= '0; ret_reg[i] <= '0; llev_reg[i] <= '0; len_reg[i] <= '0;
                oct_reg[i] <= 8'd3; vol_reg[i] <= 4'd1; per_reg[i] <= 11'd255;
                duty_reg[i] <= '0;
                for (int j = 0; j < LOOP_DEPTH; j++) begin
                    lstart_reg[i][j] <= '0; lrem_reg[i][j] <= '0;
                end
            end
            for (int i = 0; i < PULSES; i++) phase_reg[i] <= '0;
            lvl_reg <= '0;
            treload_reg <= 16'd1024; tcount_reg <= '0;
            sbyte_reg <= '0; sbit_reg <= '0; send_reg <= '0; srate_reg <= '0;
            hdr_reg <= '0;
        end else begin
            if (cmd.play) begin
                active_reg <= 1'b1;
                treload_reg <= 16'd1024; tcount_reg <= '0;
                sbyte_reg <= '0; sbit_reg <= '0; send_reg <= '0; srate_reg <= '0;
                for (int i = 0; i < 4; i++) begin
                    oct_reg[i] <= 8'd3; vol_reg[i] <= 4'd1; per_reg[i] <= 11'd255;
                end
            end
            if (cmd.tick) begin
                if (srate_reg == 8'd0) begin
                    if ((9'(sbyte_reg) + 9'd1 < 9'(send_reg)) && (sbyte_reg < 8'(DRUM_BYTES))) begin
                        lvl_reg[3] <= DRUM_ROM[sbyte_reg[6:0]][sbit_reg[2:0]];
                        if (sbit_reg == 4'd7) begin
                            sbyte_reg <= sbyte_reg + 8'd1; sbit_reg <= '0;
                        end else sbit_reg <= sbit_reg + 4'd1;
                    end else begin
                        lvl_reg[3] <= 1'b0;
                        if (sbit_reg > 4'd7) begin
                            sbyte_reg <= sbyte_reg + 8'd1; sbit_reg <= '0;
                        end
                    end
                    srate_reg <= 8'(SAMPLE_DIVIDE);
                end else srate_reg <= srate_reg - 8'd1;
                for (int i = 0; i < PULSES; i++) begin
                    logic [15:0] ph;
                    ph = phase_reg[i] + 16'(oct_reg[i]);
                    if (ph >= 16'(per_reg[i])) ph = ph - 16'(per_reg[i]);
                    phase_reg[i] <= ph;
                    lvl_reg[i] <= (ph < 16'(duty_reg[i]));
                end
                if (tcount_reg == 16'd0) tcount_reg <= treload_reg;
                else tcount_reg <= tcount_reg - 16'd1;
            end
            if (cmd.hdr_lo) begin
                hi_reg <= rdata_reg;
            end
            if (cmd.dec_len) len_reg[v] <= len_reg[v] - 7'd1;
            // Stepping the header address lets the play sequence walk the four voice pointers.
            if (cmd.set_ptr) begin
                rp_reg[v] <= ptr_asm;
                hdr_reg <= hdr_reg + AW'(2);
            end
            if (cmd.play) hdr_reg <= AW'({v, 1'b0});
            if (cmd.exec) begin
                cmdb_reg <= rdata_reg;
                priority if (ch == HI_OCTAVE) begin
                    oct_reg[v] <= 8'(9'd1 << cl);
                    rp_reg[v] <= p + AW'(1);
                end else if (ch == HI_VOLUME) begin
                    vol_reg[v] <= cl;
                    rp_reg[v] <= p + AW'(1);
                end else if (ch == HI_ESCAPE) begin
                    unique case (cl)
                        ESC_LOOP_END: begin
                            if (lrem_reg[v][top] != 8'd0) begin
                                rp_reg[v] <= lstart_reg[v][top];
                                lrem_reg[v][top] <= lrem_reg[v][top] - 8'd1;
                            end else begin
                                if (llev_reg[v] != '0) llev_reg[v] <= llev_reg[v] - CW'(1);
                                rp_reg[v] <= p + AW'(1);
                            end
                        end
                        ESC_SKIP2A, ESC_SKIP2B: rp_reg[v] <= p + AW'(2);
                        ESC_SKIP1: rp_reg[v] <= p + AW'(1);
                        ESC_RETURN: begin
                            if (ret_reg[v] != '0) begin
                                rp_reg[v] <= ret_reg[v]; ret_reg[v] <= '0;
                            end
                            hdr_reg <= AW'({v, 1'b0});
                        end
                        default: ;
                    endcase
                end else begin
                    if (ch != HI_REST) begin
                        if (v != 2'd3) begin
                            per_reg[v] <= note_period(ch - 4'd1);
                            duty_reg[v] <= note_period(ch - 4'd1) >> vol_reg[v];
                        end else begin
                            sbit_reg <= '0;
                            sbyte_reg <= drum_start((ch > 4'd6) ? 3'd5 : 3'(ch - 4'd1));
                            send_reg <= drum_start((ch > 4'd5) ? 3'd5 : 3'(ch));
                        end
                    end else duty_reg[v] <= '0;
                    len_reg[v] <= cl[3] ? 7'(8'd95 >> cl[2:0]) : 7'(8'd127 >> cl[2:0]);
                    rp_reg[v] <= p + AW'(1);
                end
            end
            if (cmd.exec_arg) begin
                unique case (cmdb_reg[3:0])
                    ESC_LOOP_START: begin
                        logic [LW-1:0] s;
                        s = (llev_reg[v] >= CW'(LOOP_DEPTH)) ? LW'(LOOP_DEPTH - 1)
                                                             : LW'(llev_reg[v]);
                        if (llev_reg[v] < CW'(LOOP_DEPTH)) llev_reg[v] <= llev_reg[v] + CW'(1);
                        lstart_reg[v][s] <= p + AW'(2);
                        lrem_reg[v][s] <= rdata_reg - 8'd1;
                        rp_reg[v] <= p + AW'(2);
                    end
                    ESC_CALL: begin
                        ret_reg[v] <= p + AW'(2);
                        hdr_reg <= AW'((17'(rdata_reg) + 17'd4) << 1);
                    end
                    ESC_TEMPO: begin
                        treload_reg <= {rdata_reg, 5'd0} & 16'hFFFF;
                        rp_reg[v] <= p + AW'(2);
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== rtl/mml_controller.sv =====
// Controller of the music player: request decode and per-voice command sequencing.
module mml_controller
    import mml_pkg::*;
#(
    parameter int MAX_COMMANDS = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic [1:0] req_type,
    output logic      in_ready,
    output logic      out_load,
    input  logic      out_free,
    input  mml_stat_t stat,
    output mml_cmd_t  cmd
);
    localparam int NW = $clog2(MAX_COMMANDS + 1);
    localparam logic [3:0] S_IDLE = 4'd0, S_HDR = 4'd1, S_HDRW = 4'd2, S_HDR2 = 4'd3,
        S_HDRSET = 4'd4, S_VOICE = 4'd5, S_FETCH = 4'd6, S_EXEC = 4'd7, S_ARG = 4'd8,
        S_ARGX = 4'd9, S_PTR = 4'd10, S_PTRW = 4'd11, S_PTR2 = 4'd12, S_PTRSET = 4'd13,
        S_DONE = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [1:0] voice_reg, voice_next;
    logic [NW-1:0] n_reg, n_next;
    logic call_reg, call_next; // the escape whose argument is read jumps through a pointer

    assign in_ready = (state_reg == S_IDLE) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; voice_reg <= '0; n_reg <= '0; call_reg <= 1'b0;
        end else begin
            state_reg <= state_next; voice_reg <= voice_next; n_reg <= n_next;
            call_reg <= call_next;
        end
    end

    always_comb begin
        state_next = state_reg; voice_next = voice_reg; n_next = n_reg;
        call_next = call_reg;
        cmd = '0; cmd.voice = voice_reg; out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    unique case (req_type)
                        REQ_LOAD: begin cmd.load = 1'b1; out_load = 1'b1; end
                        REQ_STOP: begin cmd.stop = 1'b1; out_load = 1'b1; end
                        REQ_PLAY: begin
                            cmd.play = 1'b1; cmd.voice = 2'd0; voice_next = 2'd0;
                            state_next = S_HDR;
                        end
                        default: begin
                            if (stat.active) begin
                                cmd.tick = 1'b1;
                                if (stat.reload) begin
                                    voice_next = 2'd0; state_next = S_VOICE;
                                end else out_load = 1'b1;
                            end else out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_HDR: begin cmd.rd = 1'b1; cmd.addr_sel = 2'd2; state_next = S_HDRW; end
            S_HDRW: begin cmd.hdr_lo = 1'b1; state_next = S_HDR2; end
            S_HDR2: begin cmd.rd = 1'b1; cmd.addr_sel = 2'd3; state_next = S_HDRSET; end
            S_HDRSET: begin
                cmd.set_ptr = 1'b1;
                if (voice_reg == 2'd3) begin
                    out_load = 1'b1; state_next = S_IDLE;
                end else begin
                    voice_next = voice_reg + 2'd1; state_next = S_HDR;
                end
            end
            S_VOICE: begin
                n_next = '0;
                if (!stat.len_zero) begin
                    cmd.dec_len = 1'b1; state_next = S_DONE;
                end else state_next = S_FETCH;
            end
            S_FETCH: begin
                if (n_reg == NW'(MAX_COMMANDS)) state_next = S_DONE;
                else begin
                    cmd.rd = 1'b1; cmd.addr_sel = 2'd0; state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                n_next = n_reg + NW'(1);
                call_next = stat.need_ptr;
                if (stat.need_arg) begin
                    cmd.exec = 1'b1; state_next = S_ARG;
                end else if (stat.need_ptr) begin
                    cmd.exec = 1'b1; state_next = S_PTR;
                end else begin
                    cmd.exec = 1'b1;
                    state_next = stat.done ? S_DONE : S_FETCH;
                end
            end
            S_ARG: begin cmd.rd = 1'b1; cmd.addr_sel = 2'd1; state_next = S_ARGX; end
            S_ARGX: begin
                cmd.exec_arg = 1'b1;
                state_next = call_reg ? S_PTR : S_FETCH;
            end
            S_PTR: begin cmd.rd = 1'b1; cmd.addr_sel = 2'd2; state_next = S_PTRW; end
            S_PTRW: begin cmd.hdr_lo = 1'b1; state_next = S_PTR2; end
            S_PTR2: begin cmd.rd = 1'b1; cmd.addr_sel = 2'd3; state_next = S_PTRSET; end
            S_PTRSET: begin cmd.set_ptr = 1'b1; state_next = S_FETCH; end
            S_DONE: begin
                if (voice_reg == 2'd3) begin
                    out_load = 1'b1; state_next = S_IDLE;
                end else begin
                    voice_next = voice_reg + 2'd1; state_next = S_VOICE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/mml_one_bit_music_player.sv =====
// Top level of the four-voice one-bit music player.
// One request word is taken at a time. Play reads the four header pointers; a tick on a
// tempo reload walks the four voices through the single song memory read port, at most
// MAX_COMMANDS command bytes per voice. Results wait in an output register.
module mml_one_bit_music_player
    import mml_pkg::*;
#(
    parameter int SONG_BYTES = 4096,
    parameter int LOOP_DEPTH = 4,
    parameter int SAMPLE_DIVIDE = 5,
    parameter int MAX_COMMANDS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // req_type[1:0], load_address[13:2], load_value[21:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // level_a, level_b, level_c, level_d, playing
);
    mml_cmd_t cmd;
    mml_stat_t stat;
    logic out_load;
    logic [3:0] levels;
    logic [2:0] pre_reg; // pulse levels from before a tick's update
    logic [4:0] out_reg;
    logic valid_reg;
    logic tick_acc_reg;
    logic fin_reg;

    mml_controller #(.MAX_COMMANDS(MAX_COMMANDS)) u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .req_type(s_tdata[1:0]), .in_ready(s_tready),
        .out_load, .out_free(!fin_reg && (!valid_reg || m_tready)), .stat, .cmd);

    mml_datapath #(.SONG_BYTES(SONG_BYTES), .LOOP_DEPTH(LOOP_DEPTH),
        .SAMPLE_DIVIDE(SAMPLE_DIVIDE)) u_dp (
        .aclk, .aresetn, .cmd, .load_address(s_tdata[13:2]), .load_value(s_tdata[21:14]),
        .stat, .levels);

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pre_reg <= levels[2:0]; tick_acc_reg <= (s_tdata[1:0] == REQ_TICK);
        end
    end

    // Output is formed in the cycle after the controller finishes so datapath writes settle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0; fin_reg <= 1'b0;
        end else begin
            fin_reg <= out_load;
            if (fin_reg) valid_reg <= 1'b1;
            else if (m_tready) valid_reg <= 1'b0;
        end
        if (fin_reg) begin
            out_reg <= {stat.active, levels[3],
                        tick_acc_reg ? pre_reg : levels[2:0]};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = {3'd0, out_reg[4], out_reg[3], out_reg[2], out_reg[1], out_reg[0]};
endmodule

// ===== rtl/mml_checker.sv =====
// Port-level checker for the music player, bound to the top level.
`include "mml_one_bit_music_player_defines.svh"
module mml_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);
    `MML_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `MML_ASSERT_IMP(a_pad, aclk, aresetn, m_tvalid, m_tdata[7:5] == 3'd0)
    `MML_ASSERT_NEXT(a_one, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

bind mml_one_bit_music_player mml_checker u_chk (.*);

// ===== test/mml_one_bit_music_player_tb.sv =====
// Self-checking testbench for the one-bit music player: random songs, ticks and handshake gaps.
`timescale 1ns / 1ps

module mml_one_bit_music_player_tb;
    import mml_pkg::*;

    localparam int LOOP_DEPTH = 4;
    localparam int SAMPLE_DIVIDE = 5;
    localparam int MAX_COMMANDS = 64;
    localparam int SONG_BASE = 16;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int DRAIN_CYCLES = 2000;

    typedef struct {
        bit [23:0] data;
        int        send_idle;
        int        recv_stall;
    } req_word_t;

    typedef struct {
        bit level_a;
        bit level_b;
        bit level_c;
        bit level_d;
        bit playing;
    } levels_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    mml_one_bit_music_player DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Player state as the testbench tracks it.
    bit [7:0]  song_mem [4096];
    bit        active;
    bit [11:0] voice_ptr [4];
    bit [11:0] ret_ptr [4];
    bit [11:0] rep_start [4][LOOP_DEPTH];
    bit [7:0]  rep_left [4][LOOP_DEPTH];
    bit [2:0]  rep_depth [4];
    bit [6:0]  note_len [4];
    bit [7:0]  oct_step [4];
    bit [3:0]  vol_shift [4];
    bit [10:0] wave_period [4];
    bit [10:0] duty [4];
    bit [15:0] wave_phase [3];
    bit        chan [4];
    bit [15:0] tempo_reload;
    bit [15:0] tempo_count;
    bit [7:0]  drum_byte;
    bit [3:0]  drum_bit;
    bit [7:0]  drum_stop;
    bit [7:0]  drum_div;

    bit [10:0] pitch_tab [12] = '{1024, 967, 912, 861, 813, 767, 724, 683, 645, 609, 575, 542};
    bit [7:0]  drum_first [6] = '{0, 19, 34, 74, 118, 126};

    req_word_t stim_q [$];
    levels_t   levels_q [$];
    int        cur_send_idle;
    int        cur_recv_stall;
    int        send_idle = 0;
    int        recv_stall = 0;
    int        n_words = 0;
    int        n_taken = 0;
    int        n_errors = 0;
    int        cycles = 0;
    int        hold_left = 0;
    bit        hold_done = 0;
    bit        word_taken = 0;

    function automatic bit [11:0] ptr_at(bit [11:0] a);
        bit [15:0] w;
        w = {song_mem[a], song_mem[a + 12'd1]};
        return w[11:0];
    endfunction

    function automatic void clear_player();
        active = 0;
        tempo_reload = 16'd1024;
        tempo_count = 0;
        drum_byte = 0;
        drum_bit = 0;
        drum_stop = 0;
        drum_div = 0;
        for (int v = 0; v < 4; v++) begin
            voice_ptr[v] = 0;
            ret_ptr[v] = 0;
            rep_depth[v] = 0;
            note_len[v] = 0;
            oct_step[v] = 8'd3;
            vol_shift[v] = 4'd1;
            wave_period[v] = 11'd255;
            duty[v] = 0;
            chan[v] = 0;
            for (int k = 0; k < LOOP_DEPTH; k++) begin
                rep_start[v][k] = 0;
                rep_left[v][k] = 0;
            end
        end
        for (int v = 0; v < 3; v++) wave_phase[v] = 0;
    endfunction

    function automatic void start_song();
        drum_byte = 0;
        drum_bit = 0;
        drum_stop = 0;
        drum_div = 0;
        tempo_count = 0;
        tempo_reload = 16'd1024;
        active = 1;
        for (int v = 0; v < 4; v++) begin
            voice_ptr[v] = ptr_at(12'(2 * v));
            wave_period[v] = 11'd255;
            vol_shift[v] = 4'd1;
            oct_step[v] = 8'd3;
        end
    endfunction

    function automatic void run_escape(int v, bit [3:0] lo);
        bit [11:0] p;
        bit [7:0]  x;
        int        slot;
        int        hdr;
        p = voice_ptr[v];
        x = song_mem[p + 12'd1];
        case (lo)
            ESC_LOOP_START: begin
                if (rep_depth[v] < LOOP_DEPTH) rep_depth[v]++;
                slot = rep_depth[v] - 1;
                rep_start[v][slot] = p + 12'd2;
                rep_left[v][slot] = x - 8'd1;
                voice_ptr[v] = p + 12'd2;
            end
            ESC_LOOP_END: begin
                slot = (rep_depth[v] != 0) ? rep_depth[v] - 1 : 0;
                if (slot >= LOOP_DEPTH) slot = LOOP_DEPTH - 1;
                if (rep_left[v][slot] > 0) begin
                    voice_ptr[v] = rep_start[v][slot];
                    rep_left[v][slot]--;
                end else begin
                    if (rep_depth[v] != 0) rep_depth[v]--;
                    voice_ptr[v] = p + 12'd1;
                end
            end
            ESC_CALL: begin
                ret_ptr[v] = p + 12'd2;
                hdr = (int'(x) + 4) * 2;
                voice_ptr[v] = ptr_at(hdr[11:0]);
            end
            ESC_TEMPO: begin
                tempo_reload = 16'(x) << 5;
                voice_ptr[v] = p + 12'd2;
            end
            ESC_SKIP2A, ESC_SKIP2B: voice_ptr[v] = p + 12'd2;
            ESC_SKIP1: voice_ptr[v] = p + 12'd1;
            ESC_RETURN: begin
                if (ret_ptr[v] != 0) begin
                    voice_ptr[v] = ret_ptr[v];
                    ret_ptr[v] = 0;
                end else begin
                    voice_ptr[v] = ptr_at(12'(2 * v));
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void run_voice(int v);
        bit [7:0]  b;
        bit [3:0]  hi;
        bit [3:0]  lo;
        bit [15:0] sh;
        int        first;
        int        last;
        if (note_len[v] != 0) begin
            note_len[v]--;
            return;
        end
        for (int n = 0; n < MAX_COMMANDS; n++) begin
            b = song_mem[voice_ptr[v]];
            hi = b[7:4];
            lo = b[3:0];
            if (hi == HI_ESCAPE) begin
                run_escape(v, lo);
                continue;
            end
            if (hi == HI_OCTAVE || hi == HI_VOLUME) begin
                if (hi == HI_OCTAVE) begin
                    sh = 16'd1 << lo;
                    oct_step[v] = sh[7:0];
                end else begin
                    vol_shift[v] = lo;
                end
                voice_ptr[v] = voice_ptr[v] + 12'd1;
                continue;
            end
            if (hi != HI_REST) begin
                if (v < 3) begin
                    wave_period[v] = pitch_tab[hi - 1];
                    duty[v] = wave_period[v] >> vol_shift[v];
                end else begin
                    first = (hi - 1 > 5) ? 5 : hi - 1;
                    last = (hi > 5) ? 5 : hi;
                    drum_bit = 0;
                    drum_byte = drum_first[first];
                    drum_stop = drum_first[last];
                end
            end else begin
                duty[v] = 0;
            end
            note_len[v] = (lo < 8) ? 7'(127 >> lo) : 7'(95 >> lo[2:0]);
            voice_ptr[v] = voice_ptr[v] + 12'd1;
            return;
        end
    endfunction

    function automatic void run_tick();
        bit [15:0] ph;
        if (drum_div == 0) begin
            if (int'(drum_byte) + 1 < int'(drum_stop) && drum_byte < DRUM_BYTES) begin
                chan[3] = DRUM_ROM[drum_byte][drum_bit[2:0]];
                drum_bit++;
            end else begin
                chan[3] = 0;
            end
            if (drum_bit > 7) begin
                drum_byte++;
                drum_bit = 0;
            end
            drum_div = 8'(SAMPLE_DIVIDE);
        end else begin
            drum_div--;
        end
        for (int v = 0; v < 3; v++) begin
            ph = wave_phase[v] + 16'(oct_step[v]);
            if (ph >= 16'(wave_period[v])) ph = ph - 16'(wave_period[v]);
            wave_phase[v] = ph;
            chan[v] = (ph < 16'(duty[v]));
        end
        if (tempo_count == 0) begin
            tempo_count = tempo_reload;
            for (int v = 0; v < 4; v++) run_voice(v);
        end else begin
            tempo_count--;
        end
    endfunction

    function automatic levels_t predict_levels(bit [23:0] w);
        levels_t r;
        bit [1:0] req;
        req = w[1:0];
        r.level_a = chan[0];
        r.level_b = chan[1];
        r.level_c = chan[2];
        case (req)
            REQ_LOAD: song_mem[w[13:2]] = w[21:14];
            REQ_PLAY: start_song();
            REQ_STOP: clear_player();
            default: if (active) run_tick();
        endcase
        if (req != REQ_TICK) begin
            r.level_a = chan[0];
            r.level_b = chan[1];
            r.level_c = chan[2];
        end
        r.level_d = chan[3];
        r.playing = active;
        return r;
    endfunction

    task automatic add_word(bit [1:0] req, bit [11:0] addr, bit [7:0] val);
        req_word_t it;
        it.data = {2'b00, val, addr, req};
        it.send_idle = cur_send_idle;
        it.recv_stall = cur_recv_stall;
        stim_q.push_back(it);
    endtask

    function automatic bit [7:0] random_command();
        int r;
        bit [3:0] esc [16] = '{ESC_LOOP_START, ESC_LOOP_START, ESC_LOOP_START, ESC_LOOP_END,
                               ESC_LOOP_END, ESC_LOOP_END, ESC_CALL, ESC_CALL, ESC_TEMPO,
                               ESC_SKIP2A, ESC_SKIP2B, ESC_SKIP1, ESC_RETURN, ESC_RETURN,
                               ESC_RETURN, 4'd7};
        r = $urandom_range(99);
        if (r < 45) return {4'($urandom_range(1, 12)), 4'($urandom)};
        if (r < 55) return {HI_REST, 4'($urandom)};
        if (r < 65) return {HI_OCTAVE, 4'($urandom)};
        if (r < 72) return {HI_VOLUME, 4'($urandom)};
        r = $urandom_range(15);
        // Unknown escapes stall a voice, so they stay rare.
        if (r == 15) return {HI_ESCAPE, 4'($urandom_range(7, 14))};
        return {HI_ESCAPE, esc[r]};
    endfunction

    // Writes a song whose every reachable read stays inside written bytes: argument bytes of
    // loop, call and tempo escapes are small, and a tail of restart bytes closes the body.
    task automatic load_song();
        bit [7:0] img [256];
        int nb;
        int top;
        nb = $urandom_range(24, 120);
        top = SONG_BASE + nb + 5;
        for (int v = 0; v < 4; v++) begin
            img[2 * v] = 8'd0;
            img[2 * v + 1] = (v == 0) ? 8'(SONG_BASE) : 8'(SONG_BASE + $urandom_range(nb - 1));
            img[8 + 2 * v] = 8'd0;
            img[9 + 2 * v] = 8'(SONG_BASE + $urandom_range(nb - 1));
        end
        img[SONG_BASE] = {HI_ESCAPE, ESC_TEMPO};
        img[SONG_BASE + 1] = 8'($urandom_range(3));
        for (int i = 2; i < nb; i++) begin
            if (img[SONG_BASE + i - 1] inside {{HI_ESCAPE, ESC_LOOP_START},
                                             {HI_ESCAPE, ESC_CALL}, {HI_ESCAPE, ESC_TEMPO}})
                img[SONG_BASE + i] = 8'($urandom_range(3));
            else if (i == nb - 1)
                img[SONG_BASE + i] = 8'h1F;
            else
                img[SONG_BASE + i] = random_command();
        end
        for (int i = SONG_BASE + nb; i < top; i++) img[i] = {HI_ESCAPE, ESC_RETURN};
        for (int i = 0; i < top; i++) add_word(REQ_LOAD, 12'(i), img[i]);
    endtask

    // Each play restarts the tempo count, so frequent restarts give frequent reloads.
    task automatic play_song(int n_ticks);
        add_word(REQ_PLAY, 12'($urandom), 8'($urandom));
        for (int t = 0; t < n_ticks; t++) begin
            if ($urandom_range(99) < 4)
                add_word(REQ_LOAD, 12'($urandom_range(2048, 4095)), 8'($urandom));
            if ($urandom_range(9) == 0) begin
                add_word(REQ_STOP, 12'($urandom), 8'($urandom));
                repeat ($urandom_range(1, 4)) add_word(REQ_TICK, 12'($urandom), 8'($urandom));
                add_word(REQ_PLAY, 12'($urandom), 8'($urandom));
            end
            add_word(REQ_TICK, 12'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int send_pct [4] = '{0, 66, 0, 18};
        int recv_pct [4] = '{0, 0, 66, 18};
        clear_player();
        cur_send_idle = 0;
        cur_recv_stall = 0;
        add_word(REQ_TICK, 12'hFFF, 8'hFF);
        add_word(REQ_STOP, 12'h000, 8'h00);
        add_word(REQ_LOAD, 12'hFFF, 8'hFF);
        add_word(REQ_LOAD, 12'h000, 8'h00);
        add_word(REQ_LOAD, 12'h555, 8'hAA);
        add_word(REQ_LOAD, 12'hAAA, 8'h55);
        add_word(REQ_TICK, 12'h000, 8'h00);
        for (int s = 0; s < 4; s++) begin
            cur_send_idle = send_pct[s];
            cur_recv_stall = recv_pct[s];
            add_word(REQ_STOP, 12'($urandom), 8'($urandom));
            load_song();
            play_song(70);
            // A play while already playing restarts the voices.
            if (s == 1) begin
                add_word(REQ_PLAY, 12'($urandom), 8'($urandom));
                repeat (40) add_word(REQ_TICK, 12'($urandom), 8'($urandom));
            end
        end
        add_word(REQ_STOP, 12'($urandom), 8'($urandom));
        add_word(REQ_TICK, 12'($urandom), 8'($urandom));
        n_words = stim_q.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait (n_taken == n_words && levels_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0 && levels_q.size() == 0) begin
            $display("mml_one_bit_music_player_tb: clean");
        end else begin
            $display("mml_one_bit_music_player_tb: errors");
        end
        $finish;
    end

    always @(negedge aclk) begin
        req_word_t it;
        if (aresetn && (!s_tvalid || word_taken)) begin
            if (stim_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                it = stim_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= it.data;
                send_idle = it.send_idle;
                recv_stall = it.recv_stall;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver; once, it holds off long enough for the block to back up its input.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && n_taken >= 300) begin
            hold_done = 1;
            hold_left = 400;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        levels_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("mml_one_bit_music_player_tb: errors");
            $finish;
        end else if (aresetn) begin
            word_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                levels_q.push_back(predict_levels(s_tdata));
                n_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (levels_q.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    n_errors++;
                end else begin
                    e = levels_q.pop_front();
                    if (m_tdata[0] !== e.level_a) begin
                        $error("level_a expected %0d got %0d", e.level_a, m_tdata[0]);
                        n_errors++;
                    end
                    if (m_tdata[1] !== e.level_b) begin
                        $error("level_b expected %0d got %0d", e.level_b, m_tdata[1]);
                        n_errors++;
                    end
                    if (m_tdata[2] !== e.level_c) begin
                        $error("level_c expected %0d got %0d", e.level_c, m_tdata[2]);
                        n_errors++;
                    end
                    if (m_tdata[3] !== e.level_d) begin
                        $error("level_d expected %0d got %0d", e.level_d, m_tdata[3]);
                        n_errors++;
                    end
                    if (m_tdata[4] !== e.playing) begin
                        $error("playing expected %0d got %0d", e.playing, m_tdata[4]);
                        n_errors++;
                    end
                end
            end
        end
    end

endmodule
